### rtl/core/tgad_pkg.sv
// Shared types and constants for the TGA true-color stream decoder.
`default_nettype none
package tgad_pkg;

	localparam int MAX_DIM = 8192;
	localparam int HDR_LEN = 18;
	localparam int HC_W    = 5;
	localparam int DIM_W   = 14;
	localparam int COL_W   = $clog2(MAX_DIM);
	localparam int IDX_W   = 26;

	// Header byte positions
	localparam logic [HC_W-1:0] HB_ID_LEN = 5'd0;
	localparam logic [HC_W-1:0] HB_CMAP   = 5'd1;
	localparam logic [HC_W-1:0] HB_ITYPE  = 5'd2;
	localparam logic [HC_W-1:0] HB_W_LO   = 5'd12;
	localparam logic [HC_W-1:0] HB_W_HI   = 5'd13;
	localparam logic [HC_W-1:0] HB_H_LO   = 5'd14;
	localparam logic [HC_W-1:0] HB_H_HI   = 5'd15;
	localparam logic [HC_W-1:0] HB_DEPTH  = 5'd16;
	localparam logic [HC_W-1:0] HB_DESC   = 5'd17;

	localparam logic [7:0] ITYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_24        = 8'd24;
	localparam logic [7:0] DEPTH_32        = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;
	localparam int         DESC_TOP_BIT    = 5;

	typedef enum logic [1:0] {
		KIND_HDR_OK  = 2'd0,
		KIND_HDR_BAD = 2'd1,
		KIND_PIXEL   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  id_len;
		logic [7:0]  cmap;
		logic [7:0]  itype;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  depth;
		logic        top_first;
	} hdr_t;

	typedef struct packed {
		logic ok;
		logic depth32;
	} hdr_status_t;

endpackage
`default_nettype wire

### rtl/core/tga_truecolor_stream_decoder.sv
// Top level of the TGA true-color stream decoder: header parse, ID skip, pixel packing.
// A byte accepted into the input register is processed at the next edge that the
//   output side allows; its result is then offered from the result register.
// Throughput: one byte per cycle when not stalled, set by the single-pass state update
//   between the input register and the result register; at most one result per byte.
// Reset (arst_n low, asynchronous): header capture, all counters zero, both
//   register stages empty. Header bytes are held without reset.
`default_nettype none
module tga_truecolor_stream_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       start_of_file,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic [tgad_pkg::DIM_W-1:0] image_width,
	output logic [tgad_pkg::DIM_W-1:0] image_height,
	output logic [31:0]                pixel_word,
	output logic [tgad_pkg::IDX_W-1:0] pixel_index,
	output logic                       last_pixel
);
	import tgad_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_IDLE
	} phase_t;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;

	// Decoder state
	phase_t           phase_q, phase_d;
	logic [HC_W-1:0]  hcount_q, hcount_d;
	hdr_t             hdr_q, hdr_d;
	logic [7:0]       skip_q, skip_d;
	logic [1:0]       bip_q, bip_d;
	logic [23:0]      asm_q, asm_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [COL_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] rbase_q, rbase_d;

	// Result register
	logic              out_valid_q;
	kind_t             kind_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [31:0]       word_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;

	// Result of this cycle's processing
	logic              res_valid;
	kind_t             res_kind;
	logic [DIM_W-1:0]  res_width, res_height;
	logic [31:0]       res_word;
	logic [IDX_W-1:0]  res_index;
	logic              res_last;

	hdr_status_t       hstat;
	logic              advance;
	logic              fire;
	phase_t            ph;
	logic [HC_W-1:0]   hc;
	logic [DIM_W-1:0]  w14, h14;
	logic [2*DIM_W-1:0] bottom_prod;
	logic [IDX_W-1:0]  rbase_init;
	logic [7:0]        skip_n;
	logic [23:0]       asm_n;
	logic              px_done;
	logic [DIM_W-1:0]  col_n, row_n;
	logic              px_last;

	tgad_header_check u_check (
		.hdr    (hdr_q),
		.status (hstat)
	);

	// The pipeline moves whenever the result register is free or being taken.
	assign advance  = !(out_valid_q && out_stall);
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign w14 = hdr_q.width[DIM_W-1:0];
	assign h14 = hdr_q.height[DIM_W-1:0];
	// Start of the last row for bottom-up images; dimensions are in range
	// whenever this is used, so the product fits the index width.
	assign bottom_prod = (h14 - DIM_W'(1)) * w14;

	always_comb begin
		phase_d    = phase_q;
		hcount_d   = hcount_q;
		hdr_d      = hdr_q;
		skip_d     = skip_q;
		bip_d      = bip_q;
		asm_d      = asm_q;
		col_d      = col_q;
		row_d      = row_q;
		rbase_d    = rbase_q;
		res_valid  = 1'b0;
		res_kind   = KIND_PIXEL;
		res_width  = '0;
		res_height = '0;
		res_word   = '0;
		res_index  = '0;
		res_last   = 1'b0;
		skip_n     = skip_q;
		asm_n      = asm_q;
		px_done    = 1'b0;
		col_n      = '0;
		row_n      = '0;
		px_last    = 1'b0;
		rbase_init = '0;

		// A start flag drops all progress and takes this byte as header byte 0.
		ph = sof_s1 ? PH_HEADER : phase_q;
		hc = sof_s1 ? '0 : hcount_q;

		if (fire) begin
			phase_d  = ph;
			hcount_d = hc;
			case (ph)
				PH_HEADER: begin
					case (hc)
						HB_ID_LEN: hdr_d.id_len       = byte_s1;
						HB_CMAP:   hdr_d.cmap         = byte_s1;
						HB_ITYPE:  hdr_d.itype        = byte_s1;
						HB_W_LO:   hdr_d.width[7:0]   = byte_s1;
						HB_W_HI:   hdr_d.width[15:8]  = byte_s1;
						HB_H_LO:   hdr_d.height[7:0]  = byte_s1;
						HB_H_HI:   hdr_d.height[15:8] = byte_s1;
						HB_DEPTH:  hdr_d.depth        = byte_s1;
						HB_DESC:   hdr_d.top_first    = byte_s1[DESC_TOP_BIT];
						default: ;
					endcase
					hcount_d = hc + HC_W'(1);
					if (hc == HC_W'(HDR_LEN - 1)) begin
						hcount_d   = '0;
						res_valid  = 1'b1;
						res_kind   = hstat.ok ? KIND_HDR_OK : KIND_HDR_BAD;
						res_width  = w14;
						res_height = h14;
						if (!hstat.ok) begin
							phase_d = PH_IDLE;
						end else if (hdr_q.id_len != 8'd0) begin
							skip_d  = hdr_q.id_len;
							phase_d = PH_SKIP;
						end else begin
							phase_d = PH_PIXEL;
						end
					end
				end
				PH_SKIP: begin
					skip_n = (skip_q != 8'd0) ? skip_q - 8'd1 : skip_q;
					skip_d = skip_n;
					if (skip_n == 8'd0) begin
						phase_d = PH_PIXEL;
					end
				end
				PH_PIXEL: begin
					case (bip_q)
						2'd0:    asm_n[7:0]   = byte_s1;
						2'd1:    asm_n[15:8]  = byte_s1;
						2'd2:    asm_n[23:16] = byte_s1;
						default: ;
					endcase
					px_done = hstat.depth32 ? (bip_q == 2'd3) : (bip_q == 2'd2);
					if (!px_done) begin
						bip_d = bip_q + 2'd1;
						asm_d = asm_n;
					end else begin
						col_n   = DIM_W'(col_q) + DIM_W'(1);
						row_n   = DIM_W'(row_q) + DIM_W'(1);
						px_last = (row_n >= h14) && (col_n >= w14);
						res_valid = 1'b1;
						res_kind  = KIND_PIXEL;
						res_word  = {hstat.depth32 ? byte_s1 : ALPHA_OPAQUE, asm_n};
						res_index = rbase_q + IDX_W'(col_q);
						res_last  = px_last;
						bip_d = '0;
						asm_d = '0;
						if (col_n >= w14) begin
							col_d = '0;
							row_d = row_n[COL_W-1:0];
							if (hdr_q.top_first) begin
								rbase_d = rbase_q + IDX_W'(w14);
							end else begin
								rbase_d = rbase_q - IDX_W'(w14);
							end
						end else begin
							col_d = col_n[COL_W-1:0];
						end
						if (px_last) begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: ;
			endcase

			// Entering pixel data: clear the packer and set the first row start.
			if (phase_d == PH_PIXEL && ph != PH_PIXEL) begin
				rbase_init = bottom_prod[IDX_W-1:0];
				bip_d   = '0;
				asm_d   = '0;
				col_d   = '0;
				row_d   = '0;
				rbase_d = hdr_d.top_first ? '0 : rbase_init;
			end
		end
	end

	// Input register: hold a valid byte while the downstream stage cannot advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

	// Decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hcount_q    <= '0;
			skip_q      <= '0;
			bip_q       <= '0;
			asm_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rbase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			skip_q   <= skip_d;
			bip_q    <= bip_d;
			asm_q    <= asm_d;
			col_q    <= col_d;
			row_q    <= row_d;
			rbase_q  <= rbase_d;
			if (advance) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		hdr_q <= hdr_d;
		if (advance) begin
			kind_q   <= res_kind;
			width_q  <= res_width;
			height_q <= res_height;
			word_q   <= res_word;
			index_q  <= res_index;
			last_q   <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign pixel_word   = word_q;
	assign pixel_index  = index_q;
	assign last_pixel   = last_q;

	// Final pixel flag only travels with pixel transactions.
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> kind_q == KIND_PIXEL)
		else $error("last_pixel on a header transaction");

	// Header transactions carry zero pixel fields.
	a_hdr_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_PIXEL |-> word_q == '0 && index_q == '0)
		else $error("pixel fields set on a header transaction");

	// Byte position inside a pixel stays below the bytes per pixel.
	a_bip_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXEL && !hstat.depth32 |-> bip_q != 2'd3)
		else $error("byte position past a 24-bit pixel");

	// An idle decoder makes no result until a restart.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !sof_s1 && phase_q == PH_IDLE |=> !out_valid_q)
		else $error("result produced while idle");

endmodule
`default_nettype wire

### rtl/core/tgad_header_check.sv
// Header validation for the TGA true-color stream decoder.
`default_nettype none
module tgad_header_check (
	input  tgad_pkg::hdr_t        hdr,
	output tgad_pkg::hdr_status_t status
);
	import tgad_pkg::*;

	logic depth_ok;
	logic width_ok;
	logic height_ok;

	always_comb begin
		depth_ok  = hdr.depth inside {DEPTH_24, DEPTH_32};
		width_ok  = (hdr.width != 16'd0) && (hdr.width <= 16'(MAX_DIM));
		height_ok = (hdr.height != 16'd0) && (hdr.height <= 16'(MAX_DIM));
		status.ok = (hdr.cmap == 8'd0) && (hdr.itype == ITYPE_TRUECOLOR) &&
			depth_ok && width_ok && height_ok;
		status.depth32 = (hdr.depth == DEPTH_32);
	end

endmodule
`default_nettype wire

### verif/tgad_result_checker.sv
// Result checker for the TGA true-color stream decoder: byte-level prediction and compare.
module tgad_result_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       start_of_file,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 kind,
	input  logic [tgad_pkg::DIM_W-1:0] image_width,
	input  logic [tgad_pkg::DIM_W-1:0] image_height,
	input  logic [31:0]                pixel_word,
	input  logic [tgad_pkg::IDX_W-1:0] pixel_index,
	input  logic                       last_pixel,
	output int                         awaited,
	output int                         errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import tgad_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		ST_HEADER,
		ST_SKIP,
		ST_PIXEL,
		ST_IDLE
	} parse_step_t;

	typedef struct packed {
		kind_t              kind;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [31:0]        word;
		logic [IDX_W-1:0]   index;
		logic               last;
	} tga_result_t;

	parse_step_t   step;
	int unsigned   hdr_cnt;
	logic [7:0]    hdr_bytes [HDR_LEN];
	hdr_t          hdr;
	int unsigned   skip_left;
	int unsigned   px_byte;
	logic [23:0]   px_acc;
	int unsigned   col_cnt;
	int unsigned   row_cnt;
	int unsigned   row_base;
	tga_result_t   decoded_q [$];
	int            fail_n;

	task automatic open_raster();
		px_byte  = 0;
		px_acc   = '0;
		col_cnt  = 0;
		row_cnt  = 0;
		row_base = hdr.top_first ? 0 : (32'(hdr.height) - 1) * 32'(hdr.width);
		step     = ST_PIXEL;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sof);
		tga_result_t r;
		logic        ok;
		logic [31:0] idx;
		int unsigned per;
		r = '0;
		if (sof) begin
			step    = ST_HEADER;
			hdr_cnt = 0;
		end
		case (step)
			ST_HEADER: begin
				hdr_bytes[hdr_cnt] = b;
				hdr_cnt++;
				if (hdr_cnt == HDR_LEN) begin
					hdr_cnt       = 0;
					hdr.id_len    = hdr_bytes[HB_ID_LEN];
					hdr.cmap      = hdr_bytes[HB_CMAP];
					hdr.itype     = hdr_bytes[HB_ITYPE];
					hdr.width     = {hdr_bytes[HB_W_HI], hdr_bytes[HB_W_LO]};
					hdr.height    = {hdr_bytes[HB_H_HI], hdr_bytes[HB_H_LO]};
					hdr.depth     = hdr_bytes[HB_DEPTH];
					hdr.top_first = hdr_bytes[HB_DESC][DESC_TOP_BIT];
					ok = hdr.cmap == 8'd0 && hdr.itype == ITYPE_TRUECOLOR &&
						(hdr.depth == DEPTH_24 || hdr.depth == DEPTH_32) &&
						hdr.width >= 1 && hdr.height >= 1 &&
						hdr.width <= MAX_DIM && hdr.height <= MAX_DIM;
					r.kind   = ok ? KIND_HDR_OK : KIND_HDR_BAD;
					r.width  = hdr.width[DIM_W-1:0];
					r.height = hdr.height[DIM_W-1:0];
					decoded_q.push_back(r);
					if (!ok) begin
						step = ST_IDLE;
					end else if (hdr.id_len != 8'd0) begin
						skip_left = hdr.id_len;
						step      = ST_SKIP;
					end else begin
						open_raster();
					end
				end
			end
			ST_SKIP: begin
				if (skip_left > 0)
					skip_left--;
				if (skip_left == 0)
					open_raster();
			end
			ST_PIXEL: begin
				per = (hdr.depth == DEPTH_32) ? 4 : 3;
				if (px_byte < 3)
					px_acc[8*px_byte +: 8] = b;
				px_byte++;
				if (px_byte == per) begin
					r.kind  = KIND_PIXEL;
					r.word  = {(per == 4) ? b : ALPHA_OPAQUE, px_acc};
					idx     = row_base + col_cnt;
					r.index = idx[IDX_W-1:0];
					r.last  = (row_cnt + 1 >= hdr.height) && (col_cnt + 1 >= hdr.width);
					px_byte = 0;
					px_acc  = '0;
					col_cnt++;
					if (col_cnt >= hdr.width) begin
						col_cnt = 0;
						row_cnt++;
						if (hdr.top_first)
							row_base = row_base + hdr.width;
						else
							row_base = row_base - hdr.width;
					end
					if (r.last)
						step = ST_IDLE;
					decoded_q.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		tga_result_t got;
		tga_result_t exp_r;
		got.kind   = kind_t'(kind);
		got.width  = image_width;
		got.height = image_height;
		got.word   = pixel_word;
		got.index  = pixel_index;
		got.last   = last_pixel;
		if (decoded_q.size() == 0) begin
			fail_n++;
			if (fail_n <= REPORT_LIMIT)
				$display("%t: unexpected result: kind %0d w %0d h %0d word %h idx %0d last %0b",
					$realtime, got.kind, got.width, got.height, got.word, got.index,
					got.last);
		end else begin
			exp_r = decoded_q.pop_front();
			if (got.kind !== exp_r.kind || got.width !== exp_r.width ||
				got.height !== exp_r.height || got.word !== exp_r.word ||
				got.index !== exp_r.index || got.last !== exp_r.last) begin
				fail_n++;
				if (fail_n <= REPORT_LIMIT) begin
					$display("%t: mismatch: expected kind %0d w %0d h %0d word %h idx %0d last %0b",
						$realtime, exp_r.kind, exp_r.width, exp_r.height, exp_r.word,
						exp_r.index, exp_r.last);
					$display("%t:           got kind %0d w %0d h %0d word %h idx %0d last %0b",
						$realtime, got.kind, got.width, got.height, got.word,
						got.index, got.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step      = ST_HEADER;
			hdr_cnt   = 0;
			skip_left = 0;
			px_byte   = 0;
			px_acc    = '0;
			col_cnt   = 0;
			row_cnt   = 0;
			row_base  = 0;
			fail_n    = 0;
			decoded_q.delete();
			awaited <= 0;
			errors  <= 0;
		end else begin
			// compare before predicting, so a result can never match a byte of the same edge
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				decode_byte(data_byte, start_of_file);
			awaited <= decoded_q.size();
			errors  <= fail_n;
		end
	end

endmodule

### verif/tga_truecolor_stream_decoder_tb.sv
// Testbench top for the TGA true-color stream decoder: stimulus, pacing and verdict.
module tga_truecolor_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tgad_pkg::*;

	localparam int BYTE_BUDGET  = 1600;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_GAP      = 13;
	localparam int MODE_CYCLES  = 200;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte     = '0;
	logic                 start_of_file = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [1:0]           kind;
	logic [DIM_W-1:0]     image_width;
	logic [DIM_W-1:0]     image_height;
	logic [31:0]          pixel_word;
	logic [IDX_W-1:0]     pixel_index;
	logic                 last_pixel;

	int awaited;
	int errors;
	int gap_max    = MAX_GAP;
	int sent_bytes = 0;
	int cycles     = 0;
	int hold_left  = 0;
	int mode_left  = 0;
	bit calm       = 1'b0;

	tga_truecolor_stream_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.image_width   (image_width),
		.image_height  (image_height),
		.pixel_word    (pixel_word),
		.pixel_index   (pixel_index),
		.last_pixel    (last_pixel)
	);

	tgad_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.image_width   (image_width),
		.image_height  (image_height),
		.pixel_word    (pixel_word),
		.pixel_index   (pixel_index),
		.last_pixel    (last_pixel),
		.awaited       (awaited),
		.errors        (errors)
	);

	initial forever #5 clk = ~clk;

	// Abort a hung run: the limit is many times the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tga_truecolor_stream_decoder test failed");
			$finish;
		end
	end

	// Result side: hold each result for a drawn number of cycles. At the start of each
	// mode period, draw whether it is a calm stretch in which results are taken at once.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			calm      = ($urandom_range(0, 3) == 0);
			mode_left = MODE_CYCLES;
		end
		mode_left--;
		if (out_valid && !out_stall)
			hold_left = calm ? 0 : $urandom_range(0, MAX_GAP);
		else if (out_valid && hold_left > 0)
			hold_left--;
		out_stall <= (hold_left != 0);
	end

	// Offer one byte after a drawn gap, then hold it until the transaction completes.
	// Valid stays high on return; a later gap or drain_results lowers it.
	task automatic send_byte(input logic [7:0] b, input logic sof, input bit counted);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		start_of_file <= sof;
		do @(posedge clk); while (in_stall);
		if (counted)
			sent_bytes++;
	endtask

	// Send one file: 18 header bytes, then body_len bytes of ID field and pixels.
	// Body bytes past the image end, or after a rejected header, are dropped by the
	// block and do not count toward the byte budget. fill < 0 gives random body bytes.
	task automatic send_image(input logic sof, input logic [7:0] id_len, input logic [7:0] cmap,
		input logic [7:0] itype, input int w, input int h, input logic [7:0] depth,
		input logic [7:0] desc, input int body_len, input int fill);
		logic [7:0] hb [HDR_LEN];
		bit         ok;
		int         full;
		logic [7:0] b;
		foreach (hb[i])
			hb[i] = 8'($urandom);
		hb[HB_ID_LEN] = id_len;
		hb[HB_CMAP]   = cmap;
		hb[HB_ITYPE]  = itype;
		hb[HB_W_LO]   = w[7:0];
		hb[HB_W_HI]   = w[15:8];
		hb[HB_H_LO]   = h[7:0];
		hb[HB_H_HI]   = h[15:8];
		hb[HB_DEPTH]  = depth;
		hb[HB_DESC]   = desc;
		ok = cmap == 8'd0 && itype == ITYPE_TRUECOLOR &&
			(depth == DEPTH_24 || depth == DEPTH_32) &&
			w >= 1 && h >= 1 && w <= MAX_DIM && h <= MAX_DIM;
		full = ok ? id_len + w * h * ((depth == DEPTH_32) ? 4 : 3) : 0;
		for (int i = 0; i < HDR_LEN; i++)
			send_byte(hb[i], sof && i == 0, 1'b1);
		for (int k = 0; k < body_len; k++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			send_byte(b, 1'b0, k < full);
		end
	endtask

	// Drop valid and hold the input side until every predicted result is out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	initial begin
		int         style;
		int         w;
		int         h;
		int         body;
		int         fault;
		logic [7:0] id_len;
		logic [7:0] cmap;
		logic [7:0] itype;
		logic [7:0] depth;
		logic [7:0] desc;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed files. The first one arrives with no start flag: the block is
		// already in header capture after reset.
		send_image(1'b0, 8'd0, 8'd0, ITYPE_TRUECOLOR, 1, 1, DEPTH_24, 8'h00, 5, 8'h00);
		// Largest image, bottom-up, with an ID field; take two pixels, then restart.
		send_image(1'b1, 8'd2, 8'd0, ITYPE_TRUECOLOR, MAX_DIM, MAX_DIM, DEPTH_32, 8'h00,
			10, 8'hFF);
		// Widest single row; restart in the middle of a pixel.
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, MAX_DIM, 1, DEPTH_24, 8'hDF, 5, -1);
		// Restart in the middle of the header.
		for (int i = 0; i < 7; i++)
			send_byte(8'($urandom), i == 0, 1'b1);
		// Rejected headers, each followed by bytes the block must ignore.
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 0, 4, DEPTH_24, 8'h00, 2, -1);
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 4, 0, DEPTH_32, 8'h20, 2, -1);
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, MAX_DIM + 1, 1, DEPTH_24, 8'h00, 2, -1);
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 1, MAX_DIM + 1, DEPTH_24, 8'h00, 2, -1);
		// Oversized values come back masked to the port width.
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'hFF, 2, -1);
		send_image(1'b1, 8'd0, 8'd1, ITYPE_TRUECOLOR, 2, 2, DEPTH_24, 8'h00, 2, -1);
		send_image(1'b1, 8'd0, 8'd0, 8'd10, 2, 2, DEPTH_24, 8'h00, 2, -1);
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 2, 2, 8'd16, 8'h00, 2, -1);
		// Complete images: longest ID field top-down, then bottom-up with alpha, then top-down with alpha.
		send_image(1'b1, 8'd255, 8'd0, ITYPE_TRUECOLOR, 3, 2, DEPTH_24, 8'h20,
			255 + 18 + 2, -1);
		send_image(1'b1, 8'd1, 8'd0, ITYPE_TRUECOLOR, 2, 3, DEPTH_32, 8'h00, 1 + 24, -1);
		send_image(1'b1, 8'd0, 8'd0, ITYPE_TRUECOLOR, 4, 1, DEPTH_32, 8'hFF, 16, 8'h00);
		drain_results();

		// Random files until the byte budget is spent: mostly well-formed with
		// random content, the rest broken headers, noise, and files cut short.
		while (sent_bytes < BYTE_BUDGET) begin
			style   = $urandom_range(0, 19);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			w       = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6);
			h       = $urandom_range(1, 5);
			depth   = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
			desc    = 8'($urandom);
			id_len  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
			if ($urandom_range(0, 49) == 0)
				id_len = 8'($urandom_range(5, 255));
			cmap  = 8'd0;
			itype = ITYPE_TRUECOLOR;
			body  = id_len + w * h * ((depth == DEPTH_32) ? 4 : 3);
			case (style)
				0, 1: begin
					// break exactly one acceptance rule
					fault = $urandom_range(0, 6);
					case (fault)
						0: cmap = 8'($urandom_range(1, 255));
						1: do itype = 8'($urandom); while (itype == ITYPE_TRUECOLOR);
						2: do depth = 8'($urandom); while (depth == DEPTH_24 || depth == DEPTH_32);
						3: w = 0;
						4: h = 0;
						5: w = $urandom_range(MAX_DIM + 1, 16'hFFFF);
						default: h = $urandom_range(MAX_DIM + 1, 16'hFFFF);
					endcase
					body = $urandom_range(0, 4);
				end
				2: begin
					cmap  = 8'($urandom);
					itype = 8'($urandom);
					depth = 8'($urandom);
					w     = $urandom_range(0, 16'hFFFF);
					h     = $urandom_range(0, 16'hFFFF);
					body  = $urandom_range(0, 6);
				end
				3, 4: body = $urandom_range(0, body - 1);
				5: begin
					// send a run of random bytes with no start flag; the next start flag restarts capture
					for (int i = $urandom_range(1, HDR_LEN - 1); i > 0; i--)
						send_byte(8'($urandom), i == 1 ? 1'b0 : 1'b0, 1'b1);
				end
				default: body += $urandom_range(0, 2);
			endcase
			if (style != 5)
				send_image(1'b1, id_len, cmap, itype, w, h, depth, desc, body, -1);
			if ($urandom_range(0, 29) == 0)
				drain_results();
		end

		// Let the last results out, then idle for DRAIN_CYCLES so that strays show.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tga_truecolor_stream_decoder test passed");
		else
			$display("tga_truecolor_stream_decoder test failed");
		$finish;
	end

endmodule

### sim.f
rtl/core/tgad_pkg.sv
rtl/core/tgad_header_check.sv
rtl/core/tga_truecolor_stream_decoder.sv
verif/tgad_result_checker.sv
verif/tga_truecolor_stream_decoder_tb.sv
